// ===== sv/sac_pkg.sv =====
// Shared types and constants for the segment allocator.
`default_nettype none
package sac_pkg;
	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_DESTROY = 2'd1;
	localparam logic [1:0] CMD_COMPACT = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOHOLE = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [1:0] REG_BASE = 2'd0;
	localparam logic [1:0] REG_SIZE = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	localparam logic FIT_BEST  = 1'b0;
	localparam logic FIT_WORST = 1'b1;

	localparam int ENTRY_W = 16 + 8 + 32 + 32;

	typedef struct packed {
		logic [15:0] owner;
		logic [7:0]  number;
		logic [31:0] address;
		logic [31:0] length;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INSERT,
		S_DEST_RD,
		S_DEST,
		S_COMP_RD,
		S_COMP,
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== sv/segment_allocator_with_compaction.sv =====
// Top level: segment table allocator with best/worst fit and compaction.
//
// Usage:
//  - Command channel: drive cmd/program_id/request_size with start high; the
//    beat is taken when busy is low. busy stays high until the last result.
//  - Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; write only
//    while idle. Index 0 memory_base, 1 memory_size, 2 fit_mode.
//  - Results: one beat per strobe cycle; last marks the final beat. The
//    receiver cannot stall, so there is no backpressure.
// Operation: the table lives in one RAM with a registered read, walked one
// entry per cycle. Create scans the table for a hole, decides, walks forward
// to find the insert slot, shifts the entries above it up to open it and
// writes the new entry; a create with no hole ends after the decide step, a
// create on a full table does not raise busy at all. Destroy and compact walk
// the table once (an empty table goes straight to the result); compact emits
// moves as found. The final result beat appears in the cycle in which busy
// drops.
// Reset: valid count goes to zero; RAM contents are never read until written,
// so no clearing pass is needed. Config resets to base 0, size 1 MiB, mode 0.
// Code 3 produces no result and leaves the table unchanged.
`default_nettype none
module segment_allocator_with_compaction
	import sac_pkg::*;
#(
	parameter int SEGMENTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] program_id,
	input  wire logic [31:0] request_size,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output logic             strobe,
	output logic [1:0]       status,
	output logic [31:0]      phys_addr,
	output logic [7:0]       segment_number,
	output logic [31:0]      move_source,
	output logic [31:0]      move_length,
	output logic [31:0]      freed_bytes,
	output logic             last
);
	localparam int AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CW = $clog2(SEGMENTS + 1);
	localparam logic [CW-1:0] FULL = CW'(SEGMENTS);

	logic [31:0] base_q, size_q;
	logic        mode_q;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d, idx_q, idx_d, keep_q, keep_d, pos_q, pos_d;
	logic [1:0]  cmd_q;
	logic [15:0] pid_q;
	logic [31:0] req_q;
	logic [32:0] cursor_q, cursor_d;
	logic [32:0] best_addr_q, best_addr_d, best_len_q, best_len_d;
	logic        found_q, found_d;
	logic [7:0]  maxnum_q, maxnum_d;
	logic [32:0] freed_q, freed_d;

	logic        we;
	logic [AW-1:0] waddr, raddr;
	entry_t      wdata, rd;
	logic [ENTRY_W-1:0] rd_bits;

	sac_ram #(.WIDTH(ENTRY_W), .DEPTH(SEGMENTS)) u_ram (
		.clk, .we, .waddr, .wdata(wdata), .raddr, .rdata(rd_bits)
	);
	assign rd = entry_t'(rd_bits);

	// output register
	logic        strobe_d;
	logic [1:0]  status_d;
	logic [31:0] paddr_d, msrc_d, mlen_d, freed_out_d;
	logic [7:0]  snum_d;
	logic        last_d;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= 32'd1048576;
			mode_q <= FIT_BEST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BASE: base_q <= cfg_data;
				REG_SIZE: size_q <= cfg_data;
				REG_MODE: mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	wire [32:0] mem_end = {1'b0, base_q} + {1'b0, size_q};
	wire [32:0] ent_end = {1'b0, rd.address} + {1'b0, rd.length};
	wire        at_tail = (idx_q == count_q);
	wire [32:0] stop = (!at_tail && {1'b0, rd.address} < mem_end) ?
		{1'b0, rd.address} : mem_end;
	wire [32:0] hole = stop - cursor_q;
	wire [32:0] req33 = {1'b0, req_q};

	always_comb begin
		state_d = state_q;
		count_d = count_q; idx_d = idx_q; keep_d = keep_q; pos_d = pos_q;
		cursor_d = cursor_q; best_addr_d = best_addr_q; best_len_d = best_len_q;
		found_d = found_q; maxnum_d = maxnum_q;
		freed_d = freed_q;
		we = 1'b0; waddr = '0; wdata = rd; raddr = '0;
		strobe_d = 1'b0; status_d = ST_OK; paddr_d = '0; snum_d = '0;
		msrc_d = '0; mlen_d = '0; freed_out_d = '0; last_d = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idx_d = '0; keep_d = '0;
				cursor_d = {1'b0, base_q};
				found_d = 1'b0; maxnum_d = '0; freed_d = '0;
				best_addr_d = '0; best_len_d = '0;
				if (start) begin
					case (cmd)
						CMD_CREATE: begin
							if (count_q >= FULL) begin
								strobe_d = 1'b1; status_d = ST_FULL; last_d = 1'b1;
							end else state_d = S_SCAN;
						end
						CMD_DESTROY: state_d = (count_q == '0) ? S_DONE : S_DEST;
						CMD_COMPACT: state_d = (count_q == '0) ? S_DONE : S_COMP;
						default: ;
					endcase
				end
			end
			// rd holds entry idx_q (read issued the previous cycle)
			S_SCAN: begin
				raddr = AW'(idx_q + 1'b1);
				if (stop > cursor_q) begin
					if (mode_q == FIT_BEST) begin
						if (hole >= req33 && (!found_q || hole < best_len_q)) begin
							found_d = 1'b1; best_addr_d = cursor_q; best_len_d = hole;
						end
					end else if (!found_q || hole > best_len_q) begin
						found_d = 1'b1; best_addr_d = cursor_q; best_len_d = hole;
					end
				end
				if (!at_tail) begin
					if (ent_end > cursor_q) cursor_d = ent_end;
					if (rd.owner == pid_q && rd.number > maxnum_q)
						maxnum_d = rd.number;
					idx_d = idx_q + 1'b1;
				end else state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (!found_q || best_len_q < req33) begin
					strobe_d = 1'b1; status_d = ST_NOHOLE; last_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					idx_d = '0; state_d = S_SHIFT_RD; raddr = '0;
					pos_d = count_q;
				end
			end
			// find insert position, reading forward
			S_SHIFT_RD: begin
				raddr = AW'(idx_q + 1'b1);
				if (idx_q == count_q || {1'b0, rd.address} > best_addr_q) begin
					pos_d = idx_q; idx_d = count_q;
					raddr = AW'(count_q - 1'b1);
					state_d = (idx_q == count_q) ? S_INSERT : S_SHIFT_WR;
				end else idx_d = idx_q + 1'b1;
			end
			// rd = entry idx_q-1, move it up
			S_SHIFT_WR: begin
				we = 1'b1; waddr = AW'(idx_q); wdata = rd;
				idx_d = idx_q - 1'b1;
				raddr = AW'(idx_q - 2'd2);
				if (idx_q - 1'b1 == pos_q) state_d = S_INSERT;
			end
			S_INSERT: begin
				we = 1'b1; waddr = AW'(pos_q);
				wdata.owner = pid_q; wdata.number = maxnum_q + 8'd1;
				wdata.address = best_addr_q[31:0]; wdata.length = req_q;
				count_d = count_q + 1'b1;
				strobe_d = 1'b1; paddr_d = best_addr_q[31:0];
				snum_d = maxnum_q + 8'd1; last_d = 1'b1;
				state_d = S_IDLE;
			end
			S_DEST: begin
				raddr = AW'(idx_q + 1'b1);
				if (rd.owner != pid_q) begin
					we = 1'b1; waddr = AW'(keep_q); wdata = rd;
					keep_d = keep_q + 1'b1;
				end
				idx_d = idx_q + 1'b1;
				if (idx_q + 1'b1 == count_q) begin
					count_d = (rd.owner != pid_q) ? keep_q + 1'b1 : keep_q;
					state_d = S_DONE;
				end
			end
			S_COMP: begin
				raddr = AW'(idx_q + 1'b1);
				if ({1'b0, rd.address} > cursor_q) begin
					// bit 32 set means the total already passed 32 bits: hold it
					freed_d = freed_q[32] ? freed_q :
						freed_q + ({1'b0, rd.address} - cursor_q);
					strobe_d = 1'b1; paddr_d = cursor_q[31:0];
					msrc_d = rd.address; mlen_d = rd.length;
					we = 1'b1; waddr = AW'(idx_q);
					wdata.address = cursor_q[31:0];
					cursor_d = cursor_q + {1'b0, rd.length};
				end else cursor_d = ent_end;
				idx_d = idx_q + 1'b1;
				if (idx_q + 1'b1 == count_q) state_d = S_DONE;
			end
			S_DONE: begin
				strobe_d = 1'b1; last_d = 1'b1;
				if (cmd_q == CMD_COMPACT)
					freed_out_d = freed_q[32] ? 32'hFFFF_FFFF : freed_q[31:0];
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			strobe  <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d; keep_q <= keep_d; pos_q <= pos_d;
		cursor_q <= cursor_d; best_addr_q <= best_addr_d; best_len_q <= best_len_d;
		found_q <= found_d; maxnum_q <= maxnum_d;
		freed_q <= freed_d;
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd; pid_q <= program_id; req_q <= request_size;
		end
		status <= status_d; phys_addr <= paddr_d; segment_number <= snum_d;
		move_source <= msrc_d; move_length <= mlen_d; freed_bytes <= freed_out_d;
		last <= last_d;
	end

	// Assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL) else $error("segment count above capacity");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !we) else $error("table write while idle");
	a_busy_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && state_d == S_IDLE) |=> (strobe && last))
		else $error("command finished without a last beat");
	a_grow_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INSERT |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table");
endmodule
`default_nettype wire

// ===== sv/sac_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== tb/sv/sac_checker.sv =====
// Checker: tracks the segment table, predicts every result beat and compares.
module sac_checker
	import sac_pkg::*;
#(
	parameter int SEGMENTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] program_id,
	input  wire logic [31:0] request_size,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        strobe,
	input  wire logic [1:0]  status,
	input  wire logic [31:0] phys_addr,
	input  wire logic [7:0]  segment_number,
	input  wire logic [31:0] move_source,
	input  wire logic [31:0] move_length,
	input  wire logic [31:0] freed_bytes,
	input  wire logic        last,
	output int               fail_count,
	output int               pending,
	output int               beats_checked
);
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] addr;
		logic [7:0]  number;
		logic [31:0] src;
		logic [31:0] len;
		logic [31:0] freed;
		logic        last;
	} beat_t;

	beat_t expected_beats[$];

	logic [31:0] mem_base;
	logic [31:0] mem_size;
	logic        mode;

	logic [15:0] seg_prog[SEGMENTS];
	logic [7:0]  seg_num[SEGMENTS];
	logic [31:0] seg_addr[SEGMENTS];
	logic [31:0] seg_len[SEGMENTS];
	int          seg_count;

	function automatic beat_t mk_beat(logic [1:0] st, logic [31:0] a, logic [7:0] n,
			logic [31:0] s, logic [31:0] l, logic [31:0] f, logic lst);
		beat_t b;
		b.status = st; b.addr = a; b.number = n; b.src = s;
		b.len = l; b.freed = f; b.last = lst;
		return b;
	endfunction

	task automatic alloc_segment(logic [15:0] pid, logic [31:0] req);
		longint unsigned mem_end, cursor, stop, hole, best_at, best_len, e;
		bit found;
		logic [7:0] top_num;
		int pos;
		mem_end = longint'(mem_base) + longint'(mem_size);
		cursor = mem_base;
		found = 0; best_at = 0; best_len = 0; top_num = 0;
		if (seg_count >= SEGMENTS) begin
			expected_beats.push_back(mk_beat(ST_FULL, 0, 0, 0, 0, 0, 1'b1));
			return;
		end
		for (int i = 0; i <= seg_count; i++) begin
			stop = mem_end;
			if (i < seg_count && longint'(seg_addr[i]) < mem_end)
				stop = seg_addr[i];
			if (stop > cursor) begin
				hole = stop - cursor;
				if (mode == FIT_BEST) begin
					if (hole >= req && (!found || hole < best_len)) begin
						found = 1; best_at = cursor; best_len = hole;
					end
				end else if (!found || hole > best_len) begin
					found = 1; best_at = cursor; best_len = hole;
				end
			end
			if (i < seg_count) begin
				e = longint'(seg_addr[i]) + longint'(seg_len[i]);
				if (e > cursor)
					cursor = e;
			end
		end
		if (!found || best_len < req) begin
			expected_beats.push_back(mk_beat(ST_NOHOLE, 0, 0, 0, 0, 0, 1'b1));
			return;
		end
		for (int i = 0; i < seg_count; i++)
			if (seg_prog[i] == pid && seg_num[i] > top_num)
				top_num = seg_num[i];
		top_num = top_num + 8'd1;  // wraps past 255
		pos = seg_count;
		for (int i = seg_count - 1; i >= 0; i--)
			if (longint'(seg_addr[i]) > best_at)
				pos = i;
		for (int i = seg_count; i > pos; i--) begin
			seg_prog[i] = seg_prog[i-1]; seg_num[i] = seg_num[i-1];
			seg_addr[i] = seg_addr[i-1]; seg_len[i] = seg_len[i-1];
		end
		seg_prog[pos] = pid; seg_num[pos] = top_num;
		seg_addr[pos] = best_at[31:0]; seg_len[pos] = req;
		seg_count++;
		expected_beats.push_back(mk_beat(ST_OK, best_at[31:0], top_num, 0, 0, 0, 1'b1));
	endtask

	task automatic drop_program(logic [15:0] pid);
		int kept;
		kept = 0;
		for (int i = 0; i < seg_count; i++)
			if (seg_prog[i] != pid) begin
				seg_prog[kept] = seg_prog[i]; seg_num[kept] = seg_num[i];
				seg_addr[kept] = seg_addr[i]; seg_len[kept] = seg_len[i];
				kept++;
			end
		seg_count = kept;
		expected_beats.push_back(mk_beat(ST_OK, 0, 0, 0, 0, 0, 1'b1));
	endtask

	task automatic squeeze_table();
		longint unsigned cursor, a, freed;
		cursor = mem_base;
		freed = 0;
		for (int i = 0; i < seg_count; i++) begin
			a = seg_addr[i];
			if (a > cursor) begin
				freed += a - cursor;
				expected_beats.push_back(mk_beat(ST_OK, cursor[31:0], 0, a[31:0],
					seg_len[i], 0, 1'b0));
				seg_addr[i] = cursor[31:0];
				a = cursor;
			end
			cursor = a + longint'(seg_len[i]);
		end
		if (freed > 64'hFFFF_FFFF)
			freed = 64'hFFFF_FFFF;
		expected_beats.push_back(mk_beat(ST_OK, 0, 0, 0, 0, freed[31:0], 1'b1));
	endtask

	assign pending = expected_beats.size();

	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		beat_t got;
		if (!arst_n) begin
			mem_base = 32'd0;
			mem_size = 32'd1048576;
			mode = FIT_BEST;
			seg_count = 0;
			fail_count = 0;
			beats_checked = 0;
			expected_beats.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BASE: mem_base = cfg_data;
					REG_SIZE: mem_size = cfg_data;
					REG_MODE: mode = cfg_data[0];
					default: ;
				endcase
			end
			if (strobe) begin
				got = mk_beat(status, phys_addr, segment_number, move_source,
					move_length, freed_bytes, last);
				beats_checked++;
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat %h", $time, got);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
						fail_count++;
					end
					if (got.addr !== want.addr) begin
						$display("%0t: phys_addr exp %h got %h", $time, want.addr, got.addr);
						fail_count++;
					end
					if (got.number !== want.number) begin
						$display("%0t: segment_number exp %0d got %0d", $time, want.number,
							got.number);
						fail_count++;
					end
					if (got.src !== want.src) begin
						$display("%0t: move_source exp %h got %h", $time, want.src, got.src);
						fail_count++;
					end
					if (got.len !== want.len) begin
						$display("%0t: move_length exp %h got %h", $time, want.len, got.len);
						fail_count++;
					end
					if (got.freed !== want.freed) begin
						$display("%0t: freed_bytes exp %h got %h", $time, want.freed,
							got.freed);
						fail_count++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last exp %b got %b", $time, want.last, got.last);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				case (cmd)
					CMD_CREATE:  alloc_segment(program_id, request_size);
					CMD_DESTROY: drop_program(program_id);
					CMD_COMPACT: squeeze_table();
					default: ;  // code 3: nothing happens
				endcase
			end
		end
	end
endmodule

// ===== tb/sv/testbench.sv =====
// Top: drives commands and register writes into the allocator and gives the verdict.
module testbench
	import sac_pkg::*;
();

	localparam int STALL_LIMIT = 2000;  // cycles with no beat of any kind
	localparam int SETTLE = 60;         // long enough for the longest command to finish

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  cmd = CMD_CREATE;
	logic [15:0] program_id = '0;
	logic [31:0] request_size = '0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = REG_BASE;
	logic [31:0] cfg_data = '0;
	wire         busy, cfg_ready, strobe, last;
	wire  [1:0]  status;
	wire  [31:0] phys_addr, move_source, move_length, freed_bytes;
	wire  [7:0]  segment_number;
	int          fail_count, pending, beats_checked;

	int          commands_sent = 0;
	int          stall_cycles = 0;
	logic [31:0] cur_size = 32'd1048576;  // mirror of memory_size, to aim request sizes
	bit          gaps_on = 1'b1;

	always #1 clk = ~clk;

	segment_allocator_with_compaction dut (.*);

	sac_checker chk (.*);

	// Watchdog: any accepted beat on any channel counts as progress.
	always @(posedge clk) begin
		if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// One command beat; entered and left at a falling edge. start stays high
	// across back-to-back beats.
	task automatic issue(logic [1:0] c, logic [15:0] pid, logic [31:0] req);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		start = 1'b1;
		cmd = c;
		program_id = pid;
		request_size = req;
		do @(posedge clk); while (busy);
		commands_sent++;
		@(negedge clk);
	endtask

	// Drain all expected beats, then let a possible silent command finish.
	task automatic drain();
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (idx == REG_SIZE)
			cur_size = val;
	endtask

	function automatic logic [31:0] pick_size();
		logic [31:0] cap;
		cap = (cur_size >> 3) + 32'd1;
		if (cap > 32'd100000)
			cap = 32'd100000;
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return $urandom();  // wide values, mostly no hole
			default: return $urandom_range(1, cap);
		endcase
	endfunction

	initial begin
		logic [1:0] c;
		int r;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: defaults (1 MiB, smallest fit), extremes and special cases.
		issue(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF);  // unknown code, no beat
		issue(CMD_COMPACT, 16'h0, 32'h0);          // compact of empty table
		issue(CMD_CREATE, 16'h0001, 32'd0);        // zero-length segment
		issue(CMD_CREATE, 16'h0001, 32'h100);
		issue(CMD_CREATE, 16'h0002, 32'hFFFF_FFFF); // no hole
		issue(CMD_CREATE, 16'hFFFF, 32'h1000);
		issue(CMD_DESTROY, 16'h0001, 32'h0);       // opens a gap at the bottom
		issue(CMD_DESTROY, 16'h1234, 32'h0);       // nothing to remove
		issue(CMD_COMPACT, 16'h0, 32'h0);
		for (int i = 0; i < 16; i++)               // last one finds the table full
			issue(CMD_CREATE, 16'(i % 3), 32'h40);
		drain();
		// Worst fit with a request above the largest hole, in a tiny memory.
		write_reg(REG_MODE, 32'(FIT_WORST));
		write_reg(REG_SIZE, 32'd2048);             // many segments now past the end
		issue(CMD_DESTROY, 16'h0000, 32'h0);
		issue(CMD_CREATE, 16'h0005, 32'd5000);
		issue(CMD_COMPACT, 16'h0, 32'h0);
		drain();
		write_reg(REG_BASE, 32'hFFFF_FFF0);        // segments below base
		write_reg(REG_SIZE, 32'hFFFF_FFFF);
		issue(CMD_CREATE, 16'h0007, 32'h10);
		issue(CMD_COMPACT, 16'h0, 32'h0);
		drain();
		write_reg(REG_SIZE, 32'd1);
		write_reg(REG_BASE, 32'd0);
		write_reg(REG_MODE, 32'(FIT_BEST));
		issue(CMD_DESTROY, 16'h0001, 32'h0);
		issue(CMD_DESTROY, 16'h0002, 32'h0);
		issue(CMD_DESTROY, 16'hFFFF, 32'h0);

		// Random: phases of 30 commands under random register settings.
		for (int n = 0; n < 90; n++) begin
			if (n % 30 == 0) begin
				drain();
				r = $urandom_range(0, 3);
				write_reg(REG_BASE, r == 0 ? 32'd0 : r == 1 ? 32'hFFFF_FFFF :
					r == 2 ? $urandom_range(0, 65535) : $urandom());
				r = $urandom_range(0, 4);
				write_reg(REG_SIZE, r == 0 ? 32'd1 : r == 1 ? 32'hFFFF_FFFF :
					r == 2 ? $urandom() : $urandom_range(256, 8192));
				write_reg(REG_MODE, 32'($urandom_range(0, 1)));
			end
			if (n == 50)
				drain();                           // sender waits for all results
			if (n == 70)
				gaps_on = 1'b0;                    // closing stretch at full rate
			r = $urandom_range(0, 99);
			c = r < 55 ? CMD_CREATE : r < 72 ? CMD_DESTROY : r < 94 ? CMD_COMPACT : CMD_NONE;
			issue(c, $urandom_range(0, 9) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 5)),
				pick_size());
		end

		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		$display("covered %0d commands (create/destroy/compact/unknown), %0d result beats,",
			commands_sent, beats_checked);
		$display("fit modes, full table, no-hole, zero-size and out-of-range memory windows");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
